### rtl/core/bmp_pkg.sv
// shared types, constants and helper functions of the bmp stream pixel decoder
// no dependencies; imported by the parser, the emitter and the top level
`default_nettype none

package bmp_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned PAL_DEPTH  = 256;
  localparam int          PAL_AW     = $clog2(PAL_DEPTH);
  localparam int          PAL_DW     = 24;
  localparam int          TDATA_W    = 96;

  typedef enum logic [1:0] {
    KIND_HDR = 2'd0,
    KIND_PIX = 2'd1,
    KIND_ERR = 2'd2
  } res_kind_t;

  typedef enum logic [2:0] {
    ERR_MAGIC  = 3'd0,
    ERR_HSIZE  = 3'd1,
    ERR_PLANES = 3'd2,
    ERR_DEPTH  = 3'd3,
    ERR_BEHIND = 3'd4,
    ERR_SIZE   = 3'd5
  } err_code_t;

  typedef enum logic [2:0] {
    HK_NONE  = 3'd0,
    HK_SHORT = 3'd1,
    HK_V1    = 3'd2,
    HK_V2    = 3'd3,
    HK_V3    = 3'd4,
    HK_V4    = 3'd5,
    HK_V5    = 3'd6
  } hdr_kind_t;

  localparam logic [7:0] HLEN_SHORT = 8'd12;
  localparam logic [7:0] HLEN_V1    = 8'd40;
  localparam logic [7:0] HLEN_V2    = 8'd52;
  localparam logic [7:0] HLEN_V3    = 8'd56;
  localparam logic [7:0] HLEN_V4    = 8'd108;
  localparam logic [7:0] HLEN_V5    = 8'd124;

  typedef enum logic [1:0] {
    JOB_HDR = 2'd0,
    JOB_ERR = 2'd1,
    JOB_IDX = 2'd2,
    JOB_RGB = 2'd3
  } job_kind_t;

  // work handed from the parser to the emitter, one per request with results
  typedef struct packed {
    job_kind_t   kind;
    logic [3:0]  count;
    logic [7:0]  pix_byte;
    logic [3:0]  depth;
    logic [23:0] rgb;
    logic [7:0]  alpha;
    logic [11:0] col;
    logic [11:0] line;
    err_code_t   err;
    logic [12:0] width;
    logic [12:0] height;
    logic [5:0]  bpp;
  } bmp_job_t;

  typedef struct packed {
    logic              we;
    logic [PAL_AW-1:0] addr;
    logic [PAL_DW-1:0] data;
  } pal_wr_t;

  function automatic hdr_kind_t hdr_kind_of(input logic [31:0] v);
    hdr_kind_t k;
    case (v)
      {24'd0, HLEN_SHORT}: k = HK_SHORT;
      {24'd0, HLEN_V1}:    k = HK_V1;
      {24'd0, HLEN_V2}:    k = HK_V2;
      {24'd0, HLEN_V3}:    k = HK_V3;
      {24'd0, HLEN_V4}:    k = HK_V4;
      {24'd0, HLEN_V5}:    k = HK_V5;
      default:             k = HK_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] hdr_len(input hdr_kind_t k);
    logic [7:0] l;
    case (k)
      HK_SHORT: l = HLEN_SHORT;
      HK_V1:    l = HLEN_V1;
      HK_V2:    l = HLEN_V2;
      HK_V3:    l = HLEN_V3;
      HK_V4:    l = HLEN_V4;
      HK_V5:    l = HLEN_V5;
      default:  l = 8'd0;
    endcase
    return l;
  endfunction

  function automatic logic depth_ok(input logic [15:0] d);
    return (d == 16'd1) || (d == 16'd2) || (d == 16'd4) || (d == 16'd8) ||
           (d == 16'd24) || (d == 16'd32);
  endfunction

endpackage

`default_nettype wire

### rtl/core/bmp_stream_pixel_decoder.sv
// top level of the bmp stream pixel decoder
// depends on bmp_pkg, bmp_ram, bmp_parse and bmp_emit
//
// usage:
//   in_*  : one byte of a bmp file per request, starting with the "BM" magic
//   out_* : result requests; tuser gives the kind (header, pixel, error),
//           tlast marks the last result caused by one input byte
//   the parser walks the file and info headers, writes the palette into a
//   256 x 24 ram and turns pixel bytes into jobs; the emitter expands a job
//   into results one per cycle unless stalled, looking indexed pixels up
//   in the palette
// path of a byte: job register, then palette read and output register
// throughput: one byte per cycle while bytes make at most one result and the
//   output is not stalled; a byte making more holds the input until the
//   emitter has produced its last result (up to 8 for a 1-bit indexed byte)
// reset: returns to the magic check; the palette ram is not cleared and is
//   only read at entries loaded from the file
// stall: while a shown result waits on out_tready, the output register and the
//   current job hold; a new byte is still taken while the job stage is free
// after an error or the last pixel, bytes are taken and dropped until reset
`default_nettype none

module bmp_stream_pixel_decoder
  import bmp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,   // [7:0] data_byte
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [43:32] column,
  // [55:44] line, [68:56] width, [81:69] height, [87:82] depth,
  // [90:88] error_code, [95:91] zero
  output logic [TDATA_W-1:0]      out_tdata,
  output logic [1:0]              out_tuser,  // [1:0] kind
  output logic                    out_tlast
);

  logic              job_valid, job_ready;
  bmp_job_t          job;
  pal_wr_t           pal_wr;
  logic              ram_re;
  logic [PAL_AW-1:0] ram_raddr;
  logic [PAL_DW-1:0] ram_rdata;

  assign in_tready = job_ready;

  bmp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata),
    .job_ready (job_ready),
    .job_valid (job_valid),
    .job       (job),
    .pal_wr    (pal_wr)
  );

  // palette, stored as red, green, blue from high to low
  bmp_ram #(
    .WIDTH (PAL_DW),
    .DEPTH (PAL_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_wr.we),
    .waddr (pal_wr.addr),
    .wdata (pal_wr.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bmp_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid),
    .job        (job),
    .job_ready  (job_ready),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

### rtl/core/bmp_ram.sv
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none

module bmp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/bmp_parse.sv
// byte parser: magic, file and info headers, palette load, row and pixel tracking
// depends on bmp_pkg; hands jobs to bmp_emit and palette writes to bmp_ram
`default_nettype none

module bmp_parse
  import bmp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_data,
  input  wire logic       job_ready,
  output logic            job_valid,
  output bmp_job_t        job,
  output pal_wr_t         pal_wr
);

  typedef enum logic [3:0] {
    PH_MAGIC, PH_FILEHDR, PH_INFO, PH_PALETTE, PH_SKIP, PH_PIXELS, PH_PAD, PH_DONE, PH_ERROR
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] byte_cnt_r, byte_cnt_nxt;
  logic [31:0] field_r, field_nxt;
  hdr_kind_t   hkind_r, hkind_nxt;
  logic [31:0] off_r, off_nxt;
  logic [12:0] width_r, width_nxt;
  logic [12:0] height_r, height_nxt;
  logic [15:0] planes_r, planes_nxt;
  logic [15:0] raw_r, raw_nxt;
  logic        ovs_r, ovs_nxt;
  logic [8:0]  pal_cnt_r, pal_cnt_nxt;
  logic [1:0]  sub_r, sub_nxt;
  logic [23:0] partial_r, partial_nxt;
  logic [12:0] col_r, col_nxt;
  logic [11:0] line_r, line_nxt;
  logic [1:0]  rbp_r, rbp_nxt;

  logic        acc;
  logic [31:0] cnt_inc;
  logic [31:0] field_sh;
  logic [7:0]  rel;
  logic        os2;
  logic        behind, empty, at_off;
  logic [2:0]  sub_inc;
  logic [2:0]  entry_len;
  logic [3:0]  ppb, npix;
  logic [12:0] remain;
  logic [15:0] w16, h16;

  assign acc      = in_valid && job_ready;
  assign cnt_inc  = byte_cnt_r + 32'd1;
  assign field_sh = {in_data, field_r[31:8]};
  assign rel      = byte_cnt_r[7:0] - 8'd14;
  assign os2      = (hkind_r == HK_SHORT);
  assign behind   = cnt_inc > off_r;
  assign empty    = (width_r == 13'd0) || (height_r == 13'd0);
  assign at_off   = (cnt_inc == off_r);
  assign sub_inc  = {1'b0, sub_r} + 3'd1;
  assign entry_len = os2 ? 3'd3 : 3'd4;
  assign w16      = field_sh[15:0];
  assign h16      = field_sh[31:16];
  assign remain   = width_r - col_r;

  always_comb begin
    case (raw_r[3:0])
      4'd1:    ppb = 4'd8;
      4'd2:    ppb = 4'd4;
      4'd4:    ppb = 4'd2;
      default: ppb = 4'd1;
    endcase
    npix = (remain < {9'd0, ppb}) ? remain[3:0] : ppb;
  end

  always_comb begin
    pal_wr.we   = acc && (phase_r == PH_PALETTE) && (sub_r == 2'd2);
    pal_wr.addr = pal_cnt_r[PAL_AW-1:0];
    pal_wr.data = {in_data, partial_r[7:0], partial_r[15:8]};
  end

  always_comb begin
    phase_nxt    = phase_r;
    byte_cnt_nxt = byte_cnt_r;
    field_nxt    = field_r;
    hkind_nxt    = hkind_r;
    off_nxt      = off_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    planes_nxt   = planes_r;
    raw_nxt      = raw_r;
    ovs_nxt      = ovs_r;
    pal_cnt_nxt  = pal_cnt_r;
    sub_nxt      = sub_r;
    partial_nxt  = partial_r;
    col_nxt      = col_r;
    line_nxt     = line_r;
    rbp_nxt      = rbp_r;
    job_valid    = 1'b0;
    job          = '0;
    job.kind     = JOB_ERR;
    job.err      = ERR_MAGIC;

    if (acc && (phase_r != PH_DONE) && (phase_r != PH_ERROR)) begin
      byte_cnt_nxt = cnt_inc;
      field_nxt    = field_sh;
      unique case (phase_r)
        PH_MAGIC: begin
          if (in_data != ((byte_cnt_r == 32'd0) ? 8'h42 : 8'h4D)) begin
            job_valid = 1'b1;
            job.count = 4'd1;
            job.err   = ERR_MAGIC;
            phase_nxt = PH_ERROR;
          end else if (byte_cnt_r == 32'd1) begin
            phase_nxt = PH_FILEHDR;
          end
        end
        PH_FILEHDR: begin
          if (byte_cnt_r == 32'd13) begin
            off_nxt   = field_sh;
            phase_nxt = PH_INFO;
          end
        end
        PH_INFO: begin
          if (rel == 8'd3) begin
            hkind_nxt = hdr_kind_of(field_sh);
            if (hdr_kind_of(field_sh) == HK_NONE) begin
              job_valid = 1'b1;
              job.count = 4'd1;
              job.err   = ERR_HSIZE;
              phase_nxt = PH_ERROR;
            end
          end else begin
            if (rel == 8'd7) begin
              if (os2) begin
                // short form: signed 16-bit width and height side by side
                width_nxt  = w16[12:0];
                height_nxt = h16[12:0];
                ovs_nxt    = w16[15] || (w16 > 16'(MAX_WIDTH)) ||
                             h16[15] || (h16 > 16'(MAX_HEIGHT));
              end else begin
                width_nxt = field_sh[12:0];
                if (field_sh > 32'(MAX_WIDTH)) begin
                  ovs_nxt = 1'b1;
                end
              end
            end
            if ((rel == 8'd11) && !os2) begin
              height_nxt = field_sh[12:0];
              if (field_sh > 32'(MAX_HEIGHT)) begin
                ovs_nxt = 1'b1;
              end
            end
            if (rel == (os2 ? 8'd9 : 8'd13)) begin
              planes_nxt = field_sh[31:16];
            end
            if (rel == (os2 ? 8'd11 : 8'd15)) begin
              raw_nxt = field_sh[31:16];
            end
            if (rel + 8'd1 == hdr_len(hkind_r)) begin
              // header checks in order planes, depth, size
              job_valid = 1'b1;
              job.count = 4'd1;
              if (planes_nxt != 16'd1) begin
                job.err   = ERR_PLANES;
                phase_nxt = PH_ERROR;
              end else if (!depth_ok(raw_nxt)) begin
                job.err   = ERR_DEPTH;
                phase_nxt = PH_ERROR;
              end else if (ovs_nxt) begin
                job.err   = ERR_SIZE;
                phase_nxt = PH_ERROR;
              end else begin
                job.kind   = JOB_HDR;
                job.width  = width_r;
                job.height = height_r;
                job.bpp    = raw_nxt[5:0];
                if (raw_nxt <= 16'd8) begin
                  pal_cnt_nxt = 9'd0;
                  sub_nxt     = 2'd0;
                  partial_nxt = 24'd0;
                  phase_nxt   = PH_PALETTE;
                end else if (behind) begin
                  job.count = 4'd2;
                  phase_nxt = PH_ERROR;
                end else if (empty) begin
                  phase_nxt = PH_DONE;
                end else if (at_off) begin
                  col_nxt   = 13'd0;
                  line_nxt  = 12'(height_r - 13'd1);
                  rbp_nxt   = 2'd0;
                  sub_nxt   = 2'd0;
                  phase_nxt = PH_PIXELS;
                end else begin
                  phase_nxt = PH_SKIP;
                end
              end
            end
          end
        end
        PH_PALETTE: begin
          if (sub_r != 2'd3) begin
            partial_nxt = {partial_r[15:0], in_data};
          end
          sub_nxt = sub_inc[1:0];
          if (sub_inc >= entry_len) begin
            sub_nxt     = 2'd0;
            partial_nxt = 24'd0;
            pal_cnt_nxt = pal_cnt_r + 9'd1;
            if (pal_cnt_nxt == (9'd1 << raw_r[3:0])) begin
              if (behind) begin
                job_valid = 1'b1;
                job.count = 4'd1;
                job.err   = ERR_BEHIND;
                phase_nxt = PH_ERROR;
              end else if (empty) begin
                phase_nxt = PH_DONE;
              end else if (at_off) begin
                col_nxt   = 13'd0;
                line_nxt  = 12'(height_r - 13'd1);
                rbp_nxt   = 2'd0;
                sub_nxt   = 2'd0;
                phase_nxt = PH_PIXELS;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
          end
        end
        PH_SKIP: begin
          if (at_off) begin
            col_nxt   = 13'd0;
            line_nxt  = 12'(height_r - 13'd1);
            rbp_nxt   = 2'd0;
            sub_nxt   = 2'd0;
            phase_nxt = PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          rbp_nxt = rbp_r + 2'd1;
          if (raw_r <= 16'd8) begin
            job_valid    = 1'b1;
            job.kind     = JOB_IDX;
            job.count    = npix;
            job.pix_byte = in_data;
            job.depth    = raw_r[3:0];
            job.col      = col_r[11:0];
            job.line     = line_r;
            col_nxt      = col_r + {9'd0, npix};
          end else begin
            // bytes arrive b, g, r (, a)
            case (sub_r)
              2'd0:    partial_nxt = {16'd0, in_data};
              2'd1:    partial_nxt = {8'd0, in_data, partial_r[7:0]};
              2'd2:    partial_nxt = {in_data, partial_r[15:0]};
              default: partial_nxt = partial_r;
            endcase
            sub_nxt = sub_inc[1:0];
            if (sub_inc >= ((raw_r == 16'd24) ? 3'd3 : 3'd4)) begin
              job_valid   = 1'b1;
              job.kind    = JOB_RGB;
              job.count   = 4'd1;
              job.rgb     = partial_nxt;
              job.alpha   = (raw_r == 16'd24) ? 8'hFF : in_data;
              job.col     = col_r[11:0];
              job.line    = line_r;
              sub_nxt     = 2'd0;
              partial_nxt = 24'd0;
              col_nxt     = col_r + 13'd1;
            end
          end
          if ((col_nxt >= width_r) && (sub_nxt == 2'd0)) begin
            if (rbp_nxt != 2'd0) begin
              phase_nxt = PH_PAD;
            end else if (line_r == 12'd0) begin
              phase_nxt = PH_DONE;
            end else begin
              line_nxt  = line_r - 12'd1;
              col_nxt   = 13'd0;
              sub_nxt   = 2'd0;
              phase_nxt = PH_PIXELS;
            end
          end
        end
        PH_PAD: begin
          rbp_nxt = rbp_r + 2'd1;
          if (rbp_nxt == 2'd0) begin
            if (line_r == 12'd0) begin
              phase_nxt = PH_DONE;
            end else begin
              line_nxt  = line_r - 12'd1;
              col_nxt   = 13'd0;
              sub_nxt   = 2'd0;
              phase_nxt = PH_PIXELS;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_MAGIC;
      byte_cnt_r <= '0;
      field_r    <= '0;
      hkind_r    <= HK_NONE;
      off_r      <= '0;
      width_r    <= '0;
      height_r   <= '0;
      planes_r   <= '0;
      raw_r      <= '0;
      ovs_r      <= 1'b0;
      pal_cnt_r  <= '0;
      sub_r      <= '0;
      partial_r  <= '0;
      col_r      <= '0;
      line_r     <= '0;
      rbp_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      field_r    <= field_nxt;
      hkind_r    <= hkind_nxt;
      off_r      <= off_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      planes_r   <= planes_nxt;
      raw_r      <= raw_nxt;
      ovs_r      <= ovs_nxt;
      pal_cnt_r  <= pal_cnt_nxt;
      sub_r      <= sub_nxt;
      partial_r  <= partial_nxt;
      col_r      <= col_nxt;
      line_r     <= line_nxt;
      rbp_r      <= rbp_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bmp_emit.sv
// result emitter: expands jobs into results, palette lookups, output register
// depends on bmp_pkg; reads the palette through bmp_ram
`default_nettype none

module bmp_emit
  import bmp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_valid,
  input  wire bmp_job_t          job,
  output logic                   job_ready,
  output logic                   ram_re,
  output logic [PAL_AW-1:0]      ram_raddr,
  input  wire logic [PAL_DW-1:0] ram_rdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [TDATA_W-1:0]     out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);

  // job stage
  logic        j_valid_r, j_valid_nxt;
  bmp_job_t    j_r;
  logic [2:0]  k_r;
  logic [7:0]  sh_r, sh_shift;
  logic [11:0] col_r;

  // output stage
  logic        b_valid_r;
  res_kind_t   b_kind_r;
  logic        b_from_ram_r;
  logic [23:0] b_rgb_r;
  logic [7:0]  b_alpha_r;
  logic [11:0] b_col_r, b_line_r;
  logic [12:0] b_width_r, b_height_r;
  logic [5:0]  b_bpp_r;
  err_code_t   b_err_r;
  logic        b_last_r;

  // slot being produced this cycle
  res_kind_t   s_kind;
  logic        s_from_ram;
  logic [23:0] s_rgb;
  logic [7:0]  s_alpha;
  logic [11:0] s_col, s_line;
  logic [12:0] s_width, s_height;
  logic [5:0]  s_bpp;
  err_code_t   s_err;
  logic        s_last;

  logic        adv, j_done, load;
  logic [23:0] rgb_out;

  assign adv       = j_valid_r && (!b_valid_r || out_tready);
  assign s_last    = ({1'b0, k_r} + 4'd1) == j_r.count;
  assign j_done    = adv && s_last;
  assign job_ready = !j_valid_r || j_done;
  assign load      = job_valid && job_ready;
  assign j_valid_nxt = load ? 1'b1 : (j_done ? 1'b0 : j_valid_r);

  // msb-first index field and the shift to the next one
  always_comb begin
    case (j_r.depth)
      4'd1: begin
        ram_raddr = {7'd0, sh_r[7]};
        sh_shift  = {sh_r[6:0], 1'b0};
      end
      4'd2: begin
        ram_raddr = {6'd0, sh_r[7:6]};
        sh_shift  = {sh_r[5:0], 2'b0};
      end
      4'd4: begin
        ram_raddr = {4'd0, sh_r[7:4]};
        sh_shift  = {sh_r[3:0], 4'b0};
      end
      default: begin
        ram_raddr = sh_r;
        sh_shift  = 8'd0;
      end
    endcase
  end

  assign ram_re = adv && (j_r.kind == JOB_IDX);

  always_comb begin
    s_kind     = KIND_ERR;
    s_from_ram = 1'b0;
    s_rgb      = 24'd0;
    s_alpha    = 8'd0;
    s_col      = 12'd0;
    s_line     = 12'd0;
    s_width    = 13'd0;
    s_height   = 13'd0;
    s_bpp      = 6'd0;
    s_err      = ERR_MAGIC;
    case (j_r.kind)
      JOB_HDR: begin
        if (k_r == 3'd0) begin
          s_kind   = KIND_HDR;
          s_width  = j_r.width;
          s_height = j_r.height;
          s_bpp    = j_r.bpp;
        end else begin
          // pixel offset lies behind the header
          s_err = ERR_BEHIND;
        end
      end
      JOB_ERR: begin
        s_err = j_r.err;
      end
      JOB_IDX: begin
        s_kind     = KIND_PIX;
        s_from_ram = 1'b1;
        s_alpha    = 8'hFF;
        s_col      = col_r;
        s_line     = j_r.line;
      end
      default: begin
        s_kind  = KIND_PIX;
        s_rgb   = j_r.rgb;
        s_alpha = j_r.alpha;
        s_col   = col_r;
        s_line  = j_r.line;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      j_valid_r <= j_valid_nxt;
      if (adv) begin
        b_valid_r <= 1'b1;
      end else if (out_tready) begin
        b_valid_r <= 1'b0;
      end
    end
    if (load) begin
      j_r   <= job;
      k_r   <= 3'd0;
      sh_r  <= job.pix_byte;
      col_r <= job.col;
    end else if (adv) begin
      k_r   <= k_r + 3'd1;
      sh_r  <= sh_shift;
      col_r <= col_r + 12'd1;
    end
    if (adv) begin
      b_kind_r     <= s_kind;
      b_from_ram_r <= s_from_ram;
      b_rgb_r      <= s_rgb;
      b_alpha_r    <= s_alpha;
      b_col_r      <= s_col;
      b_line_r     <= s_line;
      b_width_r    <= s_width;
      b_height_r   <= s_height;
      b_bpp_r      <= s_bpp;
      b_err_r      <= s_err;
      b_last_r     <= s_last;
    end
  end

  // palette data stays on the ram output until the next lookup is issued
  assign rgb_out    = b_from_ram_r ? ram_rdata : b_rgb_r;
  assign out_tvalid = b_valid_r;
  assign out_tuser  = b_kind_r;
  assign out_tlast  = b_last_r;
  assign out_tdata  = {5'd0, b_err_r, b_bpp_r, b_height_r, b_width_r, b_line_r, b_col_r,
                       b_alpha_r, rgb_out[7:0], rgb_out[15:8], rgb_out[23:16]};

  a_stall_holds_slot: assert property (@(posedge clk) disable iff (!rst_n)
    j_valid_r && b_valid_r && !out_tready |=> $stable(k_r) && $stable(sh_r))
    else $error("job slot advanced while output was stalled");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    j_valid_r |-> ({1'b0, k_r} < j_r.count))
    else $error("slot index beyond job count");

  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (job.count != 4'd0))
    else $error("job without results accepted");

  a_lookup_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> b_valid_r && b_from_ram_r)
    else $error("palette lookup not followed by a pixel in the output register");

endmodule

`default_nettype wire

### tb/bmp_stream_pixel_decoder_tb.sv
// self-checking testbench for bmp_stream_pixel_decoder: streams one 4-bit indexed bmp file
// with random palette, row width and pixel bytes, predicts every result and compares them
// depends on bmp_pkg and the decoder rtl
`timescale 1ns / 100ps
`default_nettype none

module bmp_stream_pixel_decoder_tb
  import bmp_pkg::*;
();

  typedef enum logic [3:0] {
    ST_MAGIC, ST_FILEHDR, ST_INFO, ST_PALETTE, ST_SKIP, ST_PIXELS, ST_PAD, ST_DONE, ST_ERROR
  } dec_state_t;

  typedef struct packed {
    res_kind_t            kind;
    logic [TDATA_W-1:0]   data;
    logic                 last;
  } bmp_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [7:0]         in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;
  logic [1:0]         out_tuser;
  logic               out_tlast;

  bmp_stream_pixel_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // decoder state mirrored by the predictor
  dec_state_t  st;
  logic [31:0] nbytes, shreg, pix_off, img_w, img_h, hdr_len_b;
  hdr_kind_t   hdr_sel;
  logic [31:0] planes_v, depth_v, pal_cnt, col_cnt, line_cnt, part_px, row_ph, sub_b;
  logic [5:0]  bpp6;
  logic        too_big;
  logic [23:0] pal_mem [256];

  bmp_result_t expected_q[$];
  bmp_result_t step_q[$];
  int          mismatches;
  bit          quiet;      // no idling on either side
  int          hold_len;   // long receiver hold-off, in cycles

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------- predictor ----------------
  task automatic add_result(input res_kind_t k, input logic [23:0] rgb, input logic [7:0] a,
                            input logic [2:0] ec, input bit hdr);
    bmp_result_t r;
    r.kind = k;
    r.data = '0;
    r.last = 1'b0;
    if (k == KIND_PIX) begin
      r.data[7:0]   = rgb[23:16];
      r.data[15:8]  = rgb[15:8];
      r.data[23:16] = rgb[7:0];
      r.data[31:24] = a;
      r.data[43:32] = col_cnt[11:0];
      r.data[55:44] = line_cnt[11:0];
      col_cnt++;
    end
    if (hdr) begin
      r.data[68:56] = img_w[12:0];
      r.data[81:69] = img_h[12:0];
      r.data[87:82] = bpp6;
    end
    if (k == KIND_ERR) begin
      r.data[90:88] = ec;
      st = ST_ERROR;
    end
    step_q.push_back(r);
  endtask

  task automatic begin_rows();
    col_cnt  = 0;
    line_cnt = img_h - 1;
    row_ph   = 0;
    sub_b    = 0;
    st       = ST_PIXELS;
  endtask

  task automatic go_pixels();
    if (nbytes > pix_off) add_result(KIND_ERR, 0, 0, ERR_BEHIND, 0);
    else if (img_w == 0 || img_h == 0) st = ST_DONE;
    else if (nbytes == pix_off) begin_rows();
    else st = ST_SKIP;
  endtask

  task automatic row_done();
    if (line_cnt == 0) st = ST_DONE;
    else begin
      line_cnt--;
      col_cnt = 0;
      sub_b   = 0;
      st      = ST_PIXELS;
    end
  endtask

  task automatic header_done();
    bit indexed;
    indexed = depth_v <= 8;
    if (planes_v != 1) add_result(KIND_ERR, 0, 0, ERR_PLANES, 0);
    else if (!(depth_v inside {1, 2, 4, 8, 24, 32}))
      add_result(KIND_ERR, 0, 0, ERR_DEPTH, 0);
    else if (too_big || (indexed && (32'd1 << depth_v) > PAL_DEPTH))
      add_result(KIND_ERR, 0, 0, ERR_SIZE, 0);
    else begin
      add_result(KIND_HDR, 0, 0, 0, 1);
      if (indexed) begin
        pal_cnt = 0;
        sub_b   = 0;
        part_px = 0;
        st      = ST_PALETTE;
      end else go_pixels();
    end
  endtask

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  task automatic info_byte(input logic [31:0] rel);
    bit short_form;
    short_form = hdr_sel == HK_SHORT;
    if (rel == 3) begin
      hdr_sel = hdr_kind_of(shreg);
      if (hdr_sel == HK_NONE) add_result(KIND_ERR, 0, 0, ERR_HSIZE, 0);
      else hdr_len_b = {24'd0, hdr_len(hdr_sel)};
      return;
    end
    if (rel == 7) begin
      img_w = short_form ? sext16(shreg[31:16]) : shreg;
      if (img_w > MAX_WIDTH) too_big = 1;
    end
    if (rel == 11 && !short_form) begin
      img_h = shreg;
      if (img_h > MAX_HEIGHT) too_big = 1;
    end
    if (short_form && rel == 7) begin
      img_w   = sext16(shreg[15:0]);
      img_h   = sext16(shreg[31:16]);
      too_big = img_w > MAX_WIDTH || img_h > MAX_HEIGHT;
    end
    if (rel == (short_form ? 9 : 13)) planes_v = shreg >> 16;
    if (rel == (short_form ? 11 : 15)) begin
      depth_v = shreg >> 16;
      bpp6    = depth_v[5:0];
    end
    if (rel + 1 == hdr_len_b) header_done();
  endtask

  // works out the results of one accepted byte and queues them
  task automatic predict_byte(input logic [7:0] b);
    logic [31:0] pos, elen, msk, used, idx, nb;
    step_q.delete();
    if (st == ST_DONE || st == ST_ERROR) return;
    pos = nbytes;
    nbytes++;
    shreg = {b, shreg[31:8]};
    case (st)
      ST_MAGIC: begin
        if (b != (pos == 0 ? 8'h42 : 8'h4D)) add_result(KIND_ERR, 0, 0, ERR_MAGIC, 0);
        else if (pos == 1) st = ST_FILEHDR;
      end
      ST_FILEHDR: begin
        if (pos == 13) begin
          pix_off = shreg;
          st      = ST_INFO;
        end
      end
      ST_INFO: info_byte(pos - 14);
      ST_PALETTE: begin
        elen = (hdr_sel == HK_SHORT) ? 3 : 4;
        if (sub_b < 3) part_px = ((part_px & 32'hFFFF) << 8) | b;
        if (sub_b == 2 && pal_cnt < PAL_DEPTH)
          pal_mem[pal_cnt] = {part_px[7:0], part_px[15:8], part_px[23:16]};
        sub_b++;
        if (sub_b >= elen) begin
          sub_b   = 0;
          part_px = 0;
          pal_cnt++;
          if (pal_cnt >= (32'd1 << (depth_v & 7)) || depth_v == 8)
            if (depth_v != 8 || pal_cnt >= 256) go_pixels();
        end
      end
      ST_SKIP: if (nbytes == pix_off) begin_rows();
      ST_PIXELS: begin
        row_ph = (row_ph + 1) & 3;
        if (depth_v <= 8) begin
          msk  = (32'd1 << depth_v) - 1;
          used = 0;
          while (used < 8 && col_cnt < img_w) begin
            idx = (b >> (8 - depth_v - used)) & msk;
            add_result(KIND_PIX, (idx < PAL_DEPTH) ? pal_mem[idx[7:0]] : 24'd0, 8'hFF, 0, 0);
            used += depth_v;
          end
        end else begin
          nb = depth_v >> 3;
          if (sub_b < 3) begin
            part_px = part_px & 32'hFFFF;
            part_px |= 32'(b) << (8 * sub_b);
          end
          sub_b++;
          if (sub_b >= nb) begin
            add_result(KIND_PIX, part_px[23:0], (nb == 4) ? b : 8'hFF, 0, 0);
            sub_b   = 0;
            part_px = 0;
          end
        end
        if (col_cnt >= img_w && sub_b == 0) begin
          if (row_ph != 0) st = ST_PAD;
          else row_done();
        end
      end
      ST_PAD: begin
        row_ph = (row_ph + 1) & 3;
        if (row_ph == 0) row_done();
      end
      default: ;
    endcase
    if (step_q.size() > 0) step_q[$].last = 1'b1;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endtask

  // ---------------- stimulus ----------------
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_byte(b);
    @(negedge clk);
  endtask

  task automatic send_word(input logic [31:0] w, input int n);
    for (int i = 0; i < n; i++) send_byte(w[8*i +: 8]);
  endtask

  int img_width, img_height, row_bytes, skip_len;

  // magic, file header and 40-byte info header of a 4-bit indexed image
  task automatic test_headers();
    img_width  = $urandom_range(1, 24);
    row_bytes  = ((img_width * 4 + 31) / 32) * 4;
    img_height = 200 / row_bytes;
    skip_len   = $urandom_range(0, 5);
    send_byte(8'h42);
    send_byte(8'h4D);
    send_word($urandom, 4);                       // file size, not checked
    send_word($urandom, 4);                       // reserved
    send_word(14 + 40 + 64 + skip_len, 4);        // pixel offset
    send_word(40, 4);
    send_word(img_width, 4);
    send_word(img_height, 4);
    send_word(1, 2);                              // planes
    send_word(4, 2);                              // bits per pixel
    for (int i = 0; i < 6; i++) send_word($urandom, 4);  // ignored tail
  endtask

  // sixteen bgr+pad entries, then the gap up to the pixel offset
  task automatic test_palette();
    for (int i = 0; i < 64; i++) send_byte($urandom_range(0, 255));
    for (int i = 0; i < skip_len; i++) send_byte($urandom_range(0, 255));
  endtask

  // pixel rows with padding; a long receiver hold-off backs up the decoder
  task automatic test_pixels();
    for (int r = 0; r < img_height; r++) begin
      if (r == 3) hold_len = 300;
      if (r == (img_height * 3) / 4) quiet = 1;
      for (int i = 0; i < row_bytes; i++) send_byte($urandom_range(0, 255));
    end
  endtask

  // bytes after the last pixel are dropped
  task automatic test_trailing();
    for (int i = 0; i < 16; i++) send_byte($urandom_range(0, 255));
    in_tvalid <= 1'b0;
  endtask

  // ---------------- receiver and checker ----------------
  initial begin
    int idle_left;
    idle_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        hold_len--;
        out_tready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) idle_left = $urandom_range(1, 14);
      end
    end
  end

  always @(posedge clk) begin
    bmp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d data=%h", out_tuser, out_tdata);
      end else begin
        want = expected_q.pop_front();
        if (out_tuser != want.kind || out_tdata != want.data || out_tlast != want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp kind=%0d data=%h last=%b, got kind=%0d data=%h last=%b",
                     want.kind, want.data, want.last, out_tuser, out_tdata, out_tlast);
        end
      end
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    int guard;
    st = ST_MAGIC;
    {nbytes, shreg, pix_off, img_w, img_h, hdr_len_b} = '0;
    {planes_v, depth_v, pal_cnt, col_cnt, line_cnt, part_px, row_ph, sub_b} = '0;
    hdr_sel    = HK_NONE;
    bpp6       = '0;
    too_big    = 1'b0;
    mismatches = 0;
    quiet      = 0;
    hold_len   = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_headers();
    test_palette();
    test_pixels();
    test_trailing();

    guard = 0;
    while (expected_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### bmp_stream_pixel_decoder.f
rtl/core/bmp_pkg.sv
rtl/core/bmp_ram.sv
rtl/core/bmp_parse.sv
rtl/core/bmp_emit.sv
rtl/core/bmp_stream_pixel_decoder.sv
tb/bmp_stream_pixel_decoder_tb.sv
